// ===== rtl/lvbd_pkg.sv =====
// lvbd_pkg: shared constants, types and command/status structs of the
// laplacian variance blur detector; no dependencies
package lvbd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_AW    = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SIZE_W     = 13;
	localparam int THR_W      = 16;
	localparam int N_W        = 25;
	localparam int WORD_W     = 64;
	localparam int ITER_W     = $clog2(WORD_W);
	localparam int VAR_W      = 14;
	localparam int FIDX_W     = 32;
	localparam int S1_W       = 32;
	localparam int S2_W       = 40;
	localparam int OUT_W      = 48;

	localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_BLUR_THRESHOLD = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PIX, ST_MLOAD, ST_MUL, ST_DLOAD, ST_DIV, ST_OUT
	} lvbd_state_t;

	typedef enum logic [1:0] {MUL_NN, MUL_A, MUL_B, MUL_T} lvbd_mul_op_t;

	typedef struct packed {
		logic         accept;
		logic         pix_step;
		logic         mul_start;
		logic         mul_step;
		logic         mul_last;
		lvbd_mul_op_t mul_op;
		logic         div_start;
		logic         div_step;
		logic         out_load;
	} lvbd_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic out_free;
	} lvbd_status_t;

endpackage

// ===== rtl/lvbd_ram.sv =====
// lvbd_ram: generic single-port ram with registered read
// no dependencies
module lvbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end
endmodule

// ===== rtl/lvbd_ctrl.sv =====
// lvbd_ctrl: sequencing state machine of the blur detector
// depends on lvbd_pkg
module lvbd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lvbd_pkg::lvbd_status_t status,
	output lvbd_pkg::lvbd_cmd_t    cmd
);
	lvbd_pkg::lvbd_state_t  state_q, state_d;
	lvbd_pkg::lvbd_mul_op_t op_q, op_d;
	logic [lvbd_pkg::ITER_W-1:0] iter_q, iter_d;
	logic iter_end;

	assign iter_end = (iter_q == {lvbd_pkg::ITER_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvbd_pkg::ST_IDLE;
			op_q    <= lvbd_pkg::MUL_NN;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		iter_d  = iter_q;
		case (state_q)
			lvbd_pkg::ST_IDLE: begin
				if (in_valid) state_d = lvbd_pkg::ST_PIX;
			end
			lvbd_pkg::ST_PIX: begin
				op_d   = lvbd_pkg::MUL_NN;
				iter_d = '0;
				state_d = status.frame_end ? lvbd_pkg::ST_MLOAD : lvbd_pkg::ST_IDLE;
			end
			lvbd_pkg::ST_MLOAD: begin
				iter_d  = '0;
				state_d = lvbd_pkg::ST_MUL;
			end
			lvbd_pkg::ST_MUL: begin
				iter_d = iter_q + 1'b1;
				if (iter_end) begin
					if (op_q == lvbd_pkg::MUL_T) begin
						state_d = lvbd_pkg::ST_DLOAD;
					end else begin
						op_d    = lvbd_pkg::lvbd_mul_op_t'(op_q + 1'b1);
						state_d = lvbd_pkg::ST_MLOAD;
					end
				end
			end
			lvbd_pkg::ST_DLOAD: begin
				iter_d  = '0;
				state_d = lvbd_pkg::ST_DIV;
			end
			lvbd_pkg::ST_DIV: begin
				iter_d = iter_q + 1'b1;
				if (iter_end) state_d = lvbd_pkg::ST_OUT;
			end
			lvbd_pkg::ST_OUT: begin
				if (status.out_free) state_d = lvbd_pkg::ST_IDLE;
			end
			default: state_d = lvbd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op = op_q;
		in_ready = 1'b0;
		case (state_q)
			lvbd_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			lvbd_pkg::ST_PIX:   cmd.pix_step  = 1'b1;
			lvbd_pkg::ST_MLOAD: cmd.mul_start = 1'b1;
			lvbd_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.mul_last = iter_end;
			end
			lvbd_pkg::ST_DLOAD: cmd.div_start = 1'b1;
			lvbd_pkg::ST_DIV:   cmd.div_step  = 1'b1;
			lvbd_pkg::ST_OUT:   cmd.out_load  = status.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

// ===== rtl/lvbd_dp.sv =====
// lvbd_dp: line stores, window, accumulators, serial multiplier and divider
// depends on lvbd_pkg and lvbd_ram
module lvbd_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [lvbd_pkg::THR_W-1:0]     cfg_data,
	input  logic [7:0]                     pix_in,
	input  lvbd_pkg::lvbd_cmd_t            cmd,
	output lvbd_pkg::lvbd_status_t         status,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [lvbd_pkg::OUT_W-1:0]     out_data
);
	localparam logic [lvbd_pkg::SIZE_W-1:0] MAXW = lvbd_pkg::SIZE_W'(lvbd_pkg::MAX_WIDTH);
	localparam logic [lvbd_pkg::SIZE_W-1:0] MAXH = lvbd_pkg::SIZE_W'(lvbd_pkg::MAX_HEIGHT);

	logic [lvbd_pkg::SIZE_W-1:0] fw_q, fh_q, w_c, h_c;
	logic [lvbd_pkg::THR_W-1:0]  thr_q;

	logic [lvbd_pkg::LINE_AW-1:0] col_q;
	logic [lvbd_pkg::ROW_W-1:0]   row_q;
	logic [lvbd_pkg::SIZE_W-1:0]  col_p1, row_p1;
	logic [7:0] pix_s1;
	logic [7:0] r0c2_q, r2c2_q, r1c1_q, r1c2_q;
	logic [7:0] l1_rdata, l2_rdata;
	logic       ram_we;

	logic signed [11:0] lap;
	logic [7:0]  lap_c;
	logic        interior, last_col, frame_end;
	logic [lvbd_pkg::S1_W-1:0] s1_q, s1_next, s1_snap_q;
	logic [lvbd_pkg::S2_W-1:0] s2_q, s2_next, s2_snap_q;
	logic [lvbd_pkg::FIDX_W-1:0] fcnt_q, fidx_q;
	logic [lvbd_pkg::N_W-1:0]    n_q;
	logic [lvbd_pkg::THR_W-1:0]  thr_snap_q;

	logic [lvbd_pkg::WORD_W-1:0] ma_q, mb_q, acc_q, acc_next;
	logic [lvbd_pkg::WORD_W-1:0] nn_q, a_q, b_q, t_q, diff;
	logic [lvbd_pkg::WORD_W-1:0] dvd_q, rem_q;
	logic [lvbd_pkg::WORD_W:0]   rem_sh;
	logic                        rem_ge;
	logic [lvbd_pkg::VAR_W-1:0]  q_q;
	logic                        blurry_q;
	logic                        out_valid_q;
	logic [lvbd_pkg::OUT_W-1:0]  out_data_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= 13'd1920;
			fh_q  <= 13'd1080;
			thr_q <= 16'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				lvbd_pkg::CFG_FRAME_WIDTH:    fw_q  <= cfg_data[lvbd_pkg::SIZE_W-1:0];
				lvbd_pkg::CFG_FRAME_HEIGHT:   fh_q  <= cfg_data[lvbd_pkg::SIZE_W-1:0];
				lvbd_pkg::CFG_BLUR_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_c = (fw_q == '0) ? 13'd1 : ((fw_q > MAXW) ? MAXW : fw_q);
	assign h_c = (fh_q == '0) ? 13'd1 : ((fh_q > MAXH) ? MAXH : fh_q);

	// line stores: line 1 holds row y-1, line 2 row y-2
	assign ram_we = cmd.pix_step;

	lvbd_ram #(.WIDTH(8), .DEPTH(lvbd_pkg::MAX_WIDTH)) u_line1 (
		.clk(clk), .we(ram_we), .addr(col_q), .wdata(pix_s1), .rdata(l1_rdata)
	);
	lvbd_ram #(.WIDTH(8), .DEPTH(lvbd_pkg::MAX_WIDTH)) u_line2 (
		.clk(clk), .we(ram_we), .addr(col_q), .wdata(l1_rdata), .rdata(l2_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) pix_s1 <= pix_in;
	end

	// laplacian of the shifted window
	assign lap = 12'(r0c2_q) + 12'(r2c2_q) + 12'(r1c1_q) + 12'(l1_rdata)
		- (12'(r1c2_q) <<< 2);
	assign lap_c = (lap < 0) ? 8'd0 : ((lap > 12'sd255) ? 8'd255 : lap[7:0]);

	assign col_p1   = {1'b0, col_q} + 13'd1;
	assign row_p1   = {1'b0, row_q} + 13'd1;
	assign interior = (col_q >= 12'd2) && (row_q >= 12'd2)
		&& ({1'b0, col_q} < w_c) && ({1'b0, row_q} < h_c);
	assign last_col  = !(col_p1 < w_c);
	assign frame_end = last_col && !(row_p1 < h_c);

	assign s1_next = interior ? s1_q + 32'(lap_c) : s1_q;
	assign s2_next = interior ? s2_q + 40'(16'(lap_c) * 16'(lap_c)) : s2_q;

	assign status.frame_end = frame_end;
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			r0c2_q <= '0;
			r2c2_q <= '0;
			r1c1_q <= '0;
			r1c2_q <= '0;
			s1_q   <= '0;
			s2_q   <= '0;
			fcnt_q <= '0;
		end else if (cmd.pix_step) begin
			r0c2_q <= l2_rdata;
			r2c2_q <= pix_s1;
			r1c1_q <= r1c2_q;
			r1c2_q <= l1_rdata;
			if (!last_col) begin
				col_q <= col_p1[lvbd_pkg::LINE_AW-1:0];
			end else begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_p1[lvbd_pkg::ROW_W-1:0];
			end
			if (frame_end) begin
				s1_q   <= '0;
				s2_q   <= '0;
				fcnt_q <= fcnt_q + 1'b1;
			end else begin
				s1_q <= s1_next;
				s2_q <= s2_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_step && frame_end) begin
			s1_snap_q  <= s1_next;
			s2_snap_q  <= s2_next;
			n_q        <= lvbd_pkg::N_W'(w_c * h_c);
			thr_snap_q <= thr_q;
			fidx_q     <= fcnt_q;
		end
	end

	// shift-add multiplier, one bit per cycle, result kept modulo 2^64
	assign acc_next = mb_q[0] ? acc_q + ma_q : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			acc_q <= '0;
			case (cmd.mul_op)
				lvbd_pkg::MUL_NN: begin ma_q <= 64'(n_q);      mb_q <= 64'(n_q);       end
				lvbd_pkg::MUL_A:  begin ma_q <= 64'(n_q);      mb_q <= 64'(s2_snap_q); end
				lvbd_pkg::MUL_B:  begin ma_q <= 64'(s1_snap_q); mb_q <= 64'(s1_snap_q); end
				lvbd_pkg::MUL_T:  begin ma_q <= nn_q;          mb_q <= 64'(thr_snap_q); end
				default:          begin ma_q <= '0;            mb_q <= '0;             end
			endcase
		end else if (cmd.mul_step) begin
			acc_q <= acc_next;
			ma_q  <= ma_q << 1;
			mb_q  <= mb_q >> 1;
			if (cmd.mul_last) begin
				case (cmd.mul_op)
					lvbd_pkg::MUL_NN: nn_q <= acc_next;
					lvbd_pkg::MUL_A:  a_q  <= acc_next;
					lvbd_pkg::MUL_B:  b_q  <= acc_next;
					lvbd_pkg::MUL_T:  t_q  <= acc_next;
					default: ;
				endcase
			end
		end
	end

	// restoring divider, one quotient bit per cycle, low bits kept
	assign diff   = (a_q >= b_q) ? a_q - b_q : '0;
	assign rem_sh = {rem_q, dvd_q[lvbd_pkg::WORD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, nn_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q    <= diff;
			rem_q    <= '0;
			q_q      <= '0;
			blurry_q <= diff < t_q;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_ge ? lvbd_pkg::WORD_W'(rem_sh - {1'b0, nn_q})
				: rem_sh[lvbd_pkg::WORD_W-1:0];
			q_q   <= {q_q[lvbd_pkg::VAR_W-2:0], rem_ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_data_q <= {1'b0, fidx_q, q_q, blurry_q};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

// ===== rtl/laplacian_variance_blur_detect.sv =====
// laplacian_variance_blur_detect: top level, 4-neighbour laplacian variance blur detector
// depends on lvbd_pkg, lvbd_ctrl, lvbd_dp
// each pixel is accepted with a line store read, then windowed, accumulated and written back;
// s_tready stays low until that is done. frame end adds four serial multiplies and a serial
// divide, plus a wait for the output register to free, before the result is valid
// arst_n clears counters, window, sums and frame number; config resets to 1920, 1080, 32
// line stores need no clearing pass
module laplacian_variance_blur_detect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // luma_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // is_blurry, variance_whole[13:0], frame_index[31:0], pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	lvbd_pkg::lvbd_cmd_t    cmd;
	lvbd_pkg::lvbd_status_t status;

	lvbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.status(status), .cmd(cmd)
	);

	lvbd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(s_tdata), .cmd(cmd), .status(status),
		.out_ready(m_tready), .out_valid(m_tvalid), .out_data(m_tdata)
	);

`ifndef NO_ASSERTIONS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.pix_step, cmd.mul_step, cmd.div_step, cmd.out_load}))
		else $error("more than one datapath command at once");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready while a transaction is in work");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !cmd.out_load)
		else $error("result loaded right after a pixel transaction");
`endif
endmodule
